// ===== rtl/quaternion_alu_macros.svh =====
`ifndef QUATERNION_ALU_MACROS_SVH
`define QUATERNION_ALU_MACROS_SVH

// Same-cycle implication check, held off while reset is active.
`define QA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("quaternion_alu: same-cycle check failed");

// Next-cycle implication check, held off while reset is active.
`define QA_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("quaternion_alu: next-cycle check failed");

`endif

// ===== rtl/qalu_pkg.sv =====
package qalu_pkg;

  // Default fraction bits of the Q format
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Sum of squares, squared norm and divider remainder width
  localparam int unsigned SW = 66;
  // Accumulator width for sums of up to four 64-bit products
  localparam int unsigned AW = 68;
  // Iterations of the divider and square root (one per stage)
  localparam int unsigned NSTEP = 33;
  // Square root partial remainder width
  localparam int unsigned RTW = 40;
  // Stages from the input register to the inverse/norm result
  localparam int unsigned LAT_INV = 5 + NSTEP + 1;

  typedef enum logic [3:0] {
    MODE_ADD    = 4'd0,
    MODE_SUB    = 4'd1,
    MODE_PROD   = 4'd2,
    MODE_SCALE  = 4'd3,
    MODE_DIV    = 4'd4,
    MODE_CONJ   = 4'd5,
    MODE_NORM   = 4'd6,
    MODE_INV    = 4'd7,
    MODE_MATRIX = 4'd8,
    MODE_EQUAL  = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // Inverse and norm results handed to the product stages
  typedef struct packed {
    logic [3:0][31:0] val;
    logic             sat;
    logic             zero;
    logic [31:0]      norm;
    logic             norm_sat;
  } inv_res_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  // Clamp a wide signed value to 32 bits
  function automatic sat_t sat32(input logic signed [AW-1:0] v);
    sat_t r;
    r.sat = !((&v[AW-1:31]) || (~|v[AW-1:31]));
    if (r.sat) begin
      r.val = v[AW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/qalu_inv.sv =====
module qalu_inv #(
  parameter int unsigned FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [3:0][31:0]    q_i,
  output qalu_pkg::inv_res_t  res_o
);

  localparam int unsigned SW    = qalu_pkg::SW;
  localparam int unsigned NSTEP = qalu_pkg::NSTEP;
  localparam int unsigned RTW   = qalu_pkg::RTW;

  // Stage 1: squares of the component magnitudes
  logic [3:0][31:0] abs_in;
  logic [3:0][31:0] q1_q;
  logic [3:0][63:0] sq1_q;

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      abs_in[t] = q_i[t][31] ? 32'(-q_i[t]) : q_i[t];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q <= q_i;
      for (int t = 0; t < 4; t++) begin
        sq1_q[t] <= 64'(abs_in[t]) * 64'(abs_in[t]);
      end
    end
  end

  // Stage 2: exact sum of squares
  logic [SW-1:0]    s2_q;
  logic [3:0][31:0] q2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= SW'(sq1_q[0]) + SW'(sq1_q[1]) + SW'(sq1_q[2]) + SW'(sq1_q[3]);
      q2_q <= q1_q;
    end
  end

  // Stage 3: squared norm rounded to the fixed-point format
  logic [SW-1:0]    n23_q;
  logic [SW-1:0]    s3_q;
  logic [3:0][31:0] q3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n23_q <= (s2_q + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      s3_q  <= s2_q;
      q3_q  <= q2_q;
    end
  end

  // Stage 4: conjugate numerators, biased by half the divisor
  logic [3:0][31:0]   abs3;
  logic [3:0]         neg3;
  logic [3:0][SW-1:0] x4_q;
  logic [3:0]         neg4_q;
  logic [SW-1:0]      n24_q;
  logic [SW-1:0]      s4_q;
  logic               zero4_q;

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      abs3[t] = q3_q[t][31] ? 32'(-q3_q[t]) : q3_q[t];
    end
    neg3[0] = q3_q[0][31];
    for (int t = 1; t < 4; t++) begin
      neg3[t] = !q3_q[t][31] && (q3_q[t] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < 4; t++) begin
        x4_q[t] <= (SW'(abs3[t]) << FRAC_BITS) + (n23_q >> 1);
      end
      neg4_q  <= neg3;
      n24_q   <= n23_q;
      s4_q    <= s3_q;
      zero4_q <= (n23_q == '0);
    end
  end

  // Step pipeline: entry 0 is the setup stage, entries 1..NSTEP one bit each
  logic [3:0][SW-1:0]    rem_q  [NSTEP+1];
  logic [3:0][NSTEP-1:0] xlo_q  [NSTEP+1];
  logic [3:0][NSTEP-1:0] quo_q  [NSTEP+1];
  logic [3:0]            ovf_q  [NSTEP+1];
  logic [3:0]            neg_q  [NSTEP+1];
  logic                  zero_q [NSTEP+1];
  logic [SW-1:0]         n2_q   [NSTEP+1];
  logic [SW-1:0]         sv_q   [NSTEP+1];
  logic [RTW-1:0]        srem_q [NSTEP+1];
  logic [NSTEP-1:0]      root_q [NSTEP+1];

  // Setup: split off the high part and flag quotients that cannot fit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < 4; t++) begin
        rem_q[0][t] <= x4_q[t] >> NSTEP;
        xlo_q[0][t] <= x4_q[t][NSTEP-1:0];
        quo_q[0][t] <= '0;
        ovf_q[0][t] <= (x4_q[t] >> NSTEP) >= n24_q;
      end
      neg_q[0]  <= neg4_q;
      zero_q[0] <= zero4_q;
      n2_q[0]   <= n24_q;
      sv_q[0]   <= s4_q;
      srem_q[0] <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [3:0][SW:0]      trial;
    logic [3:0]            ge;
    logic [3:0][SW-1:0]    rem_d;
    logic [RTW+1:0]        r2;
    logic [RTW+1:0]        rtrial;
    logic                  rge;

    // One quotient bit per lane and one root bit
    always_comb begin
      for (int t = 0; t < 4; t++) begin
        trial[t] = {rem_q[k-1][t], xlo_q[k-1][t][NSTEP-1]};
        ge[t]    = trial[t] >= {1'b0, n2_q[k-1]};
        rem_d[t] = ge[t] ? SW'(trial[t] - {1'b0, n2_q[k-1]}) : SW'(trial[t]);
      end
      r2     = {srem_q[k-1], sv_q[k-1][SW-1 -: 2]};
      rtrial = (RTW+2)'({root_q[k-1], 2'b01});
      rge    = r2 >= rtrial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int t = 0; t < 4; t++) begin
          rem_q[k][t] <= rem_d[t];
          xlo_q[k][t] <= xlo_q[k-1][t] << 1;
          quo_q[k][t] <= {quo_q[k-1][t][NSTEP-2:0], ge[t]};
        end
        ovf_q[k]  <= ovf_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        n2_q[k]   <= n2_q[k-1];
        sv_q[k]   <= sv_q[k-1] << 2;
        srem_q[k] <= rge ? RTW'(r2 - rtrial) : RTW'(r2);
        root_q[k] <= {root_q[k-1][NSTEP-2:0], rge};
      end
    end
  end

  // Final stage: sign, saturation, root rounding
  qalu_pkg::inv_res_t res_d;
  logic [3:0]         lane_sat;
  logic [NSTEP:0]     root_r;
  logic [NSTEP-1:0]   qv;

  always_comb begin
    res_d = '0;
    for (int t = 0; t < 4; t++) begin
      qv          = quo_q[NSTEP][t];
      lane_sat[t] = 1'b0;
      if (zero_q[NSTEP]) begin
        res_d.val[t] = '0;
      end else if (neg_q[NSTEP][t]) begin
        if (ovf_q[NSTEP][t] || (qv > (NSTEP'(1) << 31))) begin
          lane_sat[t]  = 1'b1;
          res_d.val[t] = 32'h8000_0000;
        end else begin
          res_d.val[t] = 32'(-qv);
        end
      end else begin
        if (ovf_q[NSTEP][t] || (qv[NSTEP-1:31] != '0)) begin
          lane_sat[t]  = 1'b1;
          res_d.val[t] = 32'h7fff_ffff;
        end else begin
          res_d.val[t] = qv[31:0];
        end
      end
    end
    res_d.sat  = (|lane_sat) && !zero_q[NSTEP];
    res_d.zero = zero_q[NSTEP];
    root_r = {1'b0, root_q[NSTEP]}
           + (NSTEP+1)'(srem_q[NSTEP] > RTW'(root_q[NSTEP]));
    res_d.norm_sat = (root_r[NSTEP:31] != '0);
    res_d.norm     = res_d.norm_sat ? 32'h7fff_ffff : root_r[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

// ===== rtl/quaternion_alu.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// input    | in_valid_i/in_ready_o | mode_i, a_*_i, b_*_i, scale_factor_i
// output   | out_valid_o/out_ready_i | out_a_o..out_d_o, row_index_o, last_o, status_o
//
// One transaction enters per cycle while in_ready_o is high. A matrix transaction emits
// four rows and holds the input side until its last row is loaded into the output
// register; every other mode emits one result per cycle unless the output stalls.
// The latency is set by the 33-stage divider and square root in qalu_inv.
// An output stall freezes the pipeline once the final stage holds a valid result;
// nothing is dropped. Reset clears the valid bits and the row counter only.
module quaternion_alu #(
  parameter int unsigned FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         mode_i,
  input  logic signed [31:0] a_real_i,
  input  logic signed [31:0] a_i_i,
  input  logic signed [31:0] a_j_i,
  input  logic signed [31:0] a_k_i,
  input  logic signed [31:0] b_real_i,
  input  logic signed [31:0] b_i_i,
  input  logic signed [31:0] b_j_i,
  input  logic signed [31:0] b_k_i,
  input  logic signed [31:0] scale_factor_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_a_o,
  output logic signed [31:0] out_b_o,
  output logic signed [31:0] out_c_o,
  output logic signed [31:0] out_d_o,
  output logic [1:0]         row_index_o,
  output logic               last_o,
  output logic [1:0]         status_o
);

  `include "quaternion_alu_macros.svh"

  localparam int unsigned AW      = qalu_pkg::AW;
  localparam int unsigned LAT_INV = qalu_pkg::LAT_INV;

  logic adv;

  // Round to nearest (ties up) and clamp
  function automatic qalu_pkg::sat_t rnd(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    r = (v + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return qalu_pkg::sat32(r);
  endfunction

  // Stage 0: input register
  logic                    v0_q;
  logic [3:0]              m0_q;
  logic [3:0][31:0]        a0_q;
  logic [3:0][31:0]        b0_q;
  logic [31:0]             s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0_q <= mode_i;
      a0_q <= {a_k_i, a_j_i, a_i_i, a_real_i};
      b0_q <= {b_k_i, b_j_i, b_i_i, b_real_i};
      s0_q <= scale_factor_i;
    end
  end

  // Inverse and norm unit; divide mode inverts b, otherwise a
  qalu_pkg::inv_res_t inv_res;

  qalu_inv #(
    .FRAC_BITS(FRAC_BITS)
  ) u_inv (
    .clk_i (clk_i),
    .en_i  (adv),
    .q_i   ((m0_q == qalu_pkg::MODE_DIV) ? b0_q : a0_q),
    .res_o (inv_res)
  );

  // Delay line matching the inverse unit
  logic             dv_q [LAT_INV];
  logic [3:0]       dm_q [LAT_INV];
  logic [3:0][31:0] da_q [LAT_INV];
  logic [3:0][31:0] db_q [LAT_INV];
  logic [31:0]      ds_q [LAT_INV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT_INV; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      dv_q[0] <= v0_q;
      for (int k = 1; k < LAT_INV; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dm_q[0] <= m0_q;
      da_q[0] <= a0_q;
      db_q[0] <= b0_q;
      ds_q[0] <= s0_q;
      for (int k = 1; k < LAT_INV; k++) begin
        dm_q[k] <= dm_q[k-1];
        da_q[k] <= da_q[k-1];
        db_q[k] <= db_q[k-1];
        ds_q[k] <= ds_q[k-1];
      end
    end
  end

  // Stage M1: sixteen products and the modes that need no multiplier
  logic [3:0]       dm;
  logic [3:0][31:0] da;
  logic [3:0][31:0] db;
  logic [3:0][31:0] xop;
  logic [3:0][31:0] yop;
  logic [3:0][31:0] smp_d;
  logic [1:0]       smpst_d;
  qalu_pkg::sat_t   sr [4];

  assign dm = dm_q[LAT_INV-1];
  assign da = da_q[LAT_INV-1];
  assign db = db_q[LAT_INV-1];

  always_comb begin
    xop = da;
    case (dm)
      qalu_pkg::MODE_DIV:    yop = inv_res.val;
      qalu_pkg::MODE_SCALE:  yop = {4{ds_q[LAT_INV-1]}};
      qalu_pkg::MODE_MATRIX: yop = da;
      default:               yop = db;
    endcase
  end

  always_comb begin
    smp_d   = '0;
    smpst_d = qalu_pkg::ST_OK;
    for (int t = 0; t < 4; t++) begin
      sr[t] = '0;
    end
    case (dm)
      qalu_pkg::MODE_ADD: begin
        for (int t = 0; t < 4; t++) begin
          sr[t]    = qalu_pkg::sat32(AW'($signed(da[t])) + AW'($signed(db[t])));
          smp_d[t] = sr[t].val;
        end
        if (sr[0].sat || sr[1].sat || sr[2].sat || sr[3].sat) smpst_d = qalu_pkg::ST_SAT;
      end
      qalu_pkg::MODE_SUB: begin
        for (int t = 0; t < 4; t++) begin
          sr[t]    = qalu_pkg::sat32(AW'($signed(da[t])) - AW'($signed(db[t])));
          smp_d[t] = sr[t].val;
        end
        if (sr[0].sat || sr[1].sat || sr[2].sat || sr[3].sat) smpst_d = qalu_pkg::ST_SAT;
      end
      qalu_pkg::MODE_CONJ: begin
        smp_d[0] = da[0];
        for (int t = 1; t < 4; t++) begin
          sr[t]    = qalu_pkg::sat32(-AW'($signed(da[t])));
          smp_d[t] = sr[t].val;
        end
        if (sr[1].sat || sr[2].sat || sr[3].sat) smpst_d = qalu_pkg::ST_SAT;
      end
      qalu_pkg::MODE_NORM: begin
        smp_d[0] = inv_res.norm;
        if (inv_res.norm_sat) smpst_d = qalu_pkg::ST_SAT;
      end
      qalu_pkg::MODE_INV: begin
        smp_d = inv_res.val;
        if (inv_res.zero) smpst_d = qalu_pkg::ST_DIV0;
        else if (inv_res.sat) smpst_d = qalu_pkg::ST_SAT;
      end
      qalu_pkg::MODE_EQUAL: begin
        smp_d[0] = (da == db) ? 32'd1 : 32'd0;
      end
      default: begin
        smp_d   = '0;
        smpst_d = qalu_pkg::ST_OK;
      end
    endcase
  end

  logic                    v1_q;
  logic [3:0]              m1_q;
  logic signed [63:0]      p1_q [4][4];
  logic [3:0][31:0]        smp1_q;
  logic [1:0]              smpst1_q;
  logic                    zero1_q;
  logic                    isat1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= dv_q[LAT_INV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q     <= dm;
      smp1_q   <= smp_d;
      smpst1_q <= smpst_d;
      zero1_q  <= inv_res.zero;
      isat1_q  <= inv_res.sat;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1_q[i][j] <= 64'(signed'(xop[i])) * 64'(signed'(yop[j]));
        end
      end
    end
  end

  // Stage M2: exact sums of products
  logic signed [AW-1:0] e [4][4];
  logic signed [AW-1:0] one2;
  logic signed [AW-1:0] sm_d [3][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = AW'(p1_q[i][j]);
      end
    end
    one2 = AW'(1) <<< (2 * FRAC_BITS);
    // rotation rows: w=0, x=1, y=2, z=3
    sm_d[1][0] = (e[1][2] + e[0][3]) <<< 1;
    sm_d[1][1] = one2 - ((e[1][1] + e[3][3]) <<< 1);
    sm_d[1][2] = (e[2][3] - e[0][1]) <<< 1;
    sm_d[1][3] = '0;
    sm_d[2][0] = (e[1][3] - e[0][2]) <<< 1;
    sm_d[2][1] = (e[2][3] + e[0][1]) <<< 1;
    sm_d[2][2] = one2 - ((e[1][1] + e[2][2]) <<< 1);
    sm_d[2][3] = '0;
    case (m1_q)
      qalu_pkg::MODE_MATRIX: begin
        sm_d[0][0] = one2 - ((e[2][2] + e[3][3]) <<< 1);
        sm_d[0][1] = (e[1][2] - e[0][3]) <<< 1;
        sm_d[0][2] = (e[1][3] + e[0][2]) <<< 1;
        sm_d[0][3] = '0;
      end
      qalu_pkg::MODE_SCALE: begin
        for (int t = 0; t < 4; t++) begin
          sm_d[0][t] = e[t][0];
        end
      end
      default: begin
        sm_d[0][0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
        sm_d[0][1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
        sm_d[0][2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
        sm_d[0][3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
      end
    endcase
  end

  logic                 v2_q;
  logic [3:0]           m2_q;
  logic signed [AW-1:0] sm2_q [3][4];
  logic [3:0][31:0]     smp2_q;
  logic [1:0]           smpst2_q;
  logic                 zero2_q;
  logic                 isat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_q     <= m1_q;
      sm2_q    <= sm_d;
      smp2_q   <= smp1_q;
      smpst2_q <= smpst1_q;
      zero2_q  <= zero1_q;
      isat2_q  <= isat1_q;
    end
  end

  // Stage M3: round, clamp and pick the result for the mode
  qalu_pkg::sat_t   rr [3][4];
  logic [2:0]       rsat;
  logic [31:0]      fv_d [3][4];
  logic [1:0]       fst_d [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        rr[r][c] = rnd(sm2_q[r][c]);
        fv_d[r][c] = rr[r][c].val;
      end
      rsat[r]  = rr[r][0].sat || rr[r][1].sat || rr[r][2].sat || rr[r][3].sat;
      fst_d[r] = rsat[r] ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
    end
    case (m2_q)
      qalu_pkg::MODE_PROD, qalu_pkg::MODE_SCALE, qalu_pkg::MODE_MATRIX: begin
      end
      qalu_pkg::MODE_DIV: begin
        if (zero2_q) begin
          for (int c = 0; c < 4; c++) begin
            fv_d[0][c] = '0;
          end
          fst_d[0] = qalu_pkg::ST_DIV0;
        end else if (rsat[0] || isat2_q) begin
          fst_d[0] = qalu_pkg::ST_SAT;
        end
      end
      default: begin
        for (int c = 0; c < 4; c++) begin
          fv_d[0][c] = smp2_q[c];
        end
        fst_d[0] = smpst2_q;
      end
    endcase
  end

  logic        fin_v_q;
  logic        fin_mat_q;
  logic [31:0] fin_val_q [3][4];
  logic [1:0]  fin_st_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (adv) begin
      fin_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_mat_q <= (m2_q == qalu_pkg::MODE_MATRIX);
      fin_val_q <= fv_d;
      fin_st_q  <= fst_d;
    end
  end

  // Output register and matrix row sequencer
  logic        out_free;
  logic        last_row;
  logic        load;
  logic        row3;
  logic [1:0]  row_q;
  logic        out_v_q;
  logic [31:0] out_val_q [4];
  logic [1:0]  out_row_q;
  logic        out_last_q;
  logic [1:0]  out_st_q;

  assign out_free = !out_v_q || out_ready_i;
  assign last_row = !fin_mat_q || (row_q == 2'd3);
  assign load     = fin_v_q && out_free;
  assign adv      = !fin_v_q || (out_free && last_row);
  assign row3     = (row_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      row_q   <= 2'd0;
    end else begin
      if (load) begin
        out_v_q <= 1'b1;
        row_q   <= last_row ? 2'd0 : row_q + 2'd1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int c = 0; c < 4; c++) begin
        out_val_q[c] <= row3 ? ((c == 3) ? (32'(1) << FRAC_BITS) : 32'd0)
                             : fin_val_q[row_q][c];
      end
      out_row_q  <= row_q;
      out_last_q <= last_row;
      out_st_q   <= row3 ? qalu_pkg::ST_OK : fin_st_q[row_q];
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = out_v_q;
  assign out_a_o     = out_val_q[0];
  assign out_b_o     = out_val_q[1];
  assign out_c_o     = out_val_q[2];
  assign out_d_o     = out_val_q[3];
  assign row_index_o = out_row_q;
  assign last_o      = out_last_q;
  assign status_o    = out_st_q;

  // Checks
  `QA_ASSERT_IMP(a_last_row, clk_i, rst_ni, out_valid_o && last_o, row_index_o == 2'd0 || row_index_o == 2'd3)
  `QA_ASSERT_IMP(a_hold_in, clk_i, rst_ni, fin_v_q && fin_mat_q && row_q != 2'd3, !in_ready_o)
  `QA_ASSERT_IMP(a_div0_zero, clk_i, rst_ni, out_valid_o && status_o == qalu_pkg::ST_DIV0, out_a_o == 32'd0 && out_b_o == 32'd0 && out_c_o == 32'd0 && out_d_o == 32'd0)
  `QA_ASSERT_NXT(a_row_follow, clk_i, rst_ni, out_valid_o && out_ready_i && !last_o, out_valid_o)

endmodule
